// ----- hw/rtl/stream_substring_replace_assert.svh -----
// Assertion macros shared by the substring replace RTL.
// Used by the files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef STREAM_SUBSTRING_REPLACE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SSR_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SSR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SSR_ASSERT_IMPLY(name, ante, cons)

`define SSR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ----- hw/rtl/ssr_pkg.sv -----
// Shared types and constants for the substring replace block.
// No dependencies.
package ssr_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;
    localparam int LEN_CFG_W   = 4;
    localparam int BURST_CNT_W = 4;
    localparam int REPL_MAX    = 8;
    localparam int BURST_W     = REPL_MAX * BYTE_W;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES,
        REG_PATTERN_LEN,
        REG_REPL_BYTES,
        REG_REPL_LEN
    } t_reg_idx;

    typedef struct packed {
        logic [BURST_W-1:0]     data;
        logic [BURST_CNT_W-1:0] cnt;
        logic                   has;
        logic                   last;
    } t_burst;

endpackage

// ----- hw/rtl/ssr_if.sv -----
// Valid/ready stream interfaces for the substring replace block.
// Input channel carries a source byte, output channel a rewritten byte; no dependencies.
interface ssr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ssr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

// ----- hw/rtl/ssr_window.sv -----
// Match window: holds up to pattern-length bytes, compares and builds the result burst.
// Depends on ssr_pkg and the assertion macro header.
`include "stream_substring_replace_assert.svh"

module ssr_window #(
    parameter int PATTERN_MAX = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_clear,
    input  logic [ssr_pkg::BYTE_W-1:0]          i_byte,
    input  logic                                i_last,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]      i_pattern,
    input  logic [ssr_pkg::LEN_CFG_W-1:0]       i_pattern_len,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]      i_repl,
    input  logic [ssr_pkg::LEN_CFG_W-1:0]       i_repl_len,
    output ssr_pkg::t_burst                     o_burst
);
    import ssr_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [BYTE_W-1:0] r_win [PATTERN_MAX];
    logic [BYTE_W-1:0] n_win [PATTERN_MAX];
    logic [BYTE_W-1:0] w_ins [PATTERN_MAX];
    logic [LEN_W-1:0]  r_fill;
    logic [LEN_W-1:0]  n_fill;
    logic [LEN_W-1:0]  w_plen;
    logic [LEN_W-1:0]  w_fill;
    logic [LEN_W-1:0]  w_fill_inc;
    logic [LEN_CFG_W-1:0] w_rlen;
    logic [BURST_W-1:0]   w_flat;
    logic              w_full;
    logic              w_eq;

    always_comb begin
        if (i_pattern_len == '0) begin
            w_plen = LEN_W'(1);
        end else if (i_pattern_len > LEN_CFG_W'(PATTERN_MAX)) begin
            w_plen = LEN_W'(PATTERN_MAX);
        end else begin
            w_plen = LEN_W'(i_pattern_len);
        end
        w_rlen = (i_repl_len > LEN_CFG_W'(REPL_MAX)) ? LEN_CFG_W'(REPL_MAX) : i_repl_len;
    end

    assign w_fill     = (r_fill >= w_plen) ? w_plen - LEN_W'(1) : r_fill;
    assign w_fill_inc = w_fill + LEN_W'(1);
    assign w_full     = (w_fill_inc == w_plen);

    always_comb begin
        w_flat = '0;
        w_eq   = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_ins[i] = (LEN_W'(i) == w_fill) ? i_byte : r_win[i];
            w_flat[i*BYTE_W +: BYTE_W] = w_ins[i];
            if ((LEN_W'(i) < w_plen) && (w_ins[i] != i_pattern[i*BYTE_W +: BYTE_W])) begin
                w_eq = 1'b0;
            end
        end
    end

    always_comb begin
        n_win   = w_ins;
        n_fill  = w_fill_inc;
        o_burst = '0;
        o_burst.last = i_last;
        if (w_full && w_eq) begin
            n_fill       = '0;
            o_burst.data = BURST_W'(i_repl);
            o_burst.cnt  = BURST_CNT_W'(w_rlen);
            o_burst.has  = 1'b1;
            if (i_last && (w_rlen == '0)) begin
                o_burst.data = '0;
                o_burst.cnt  = BURST_CNT_W'(1);
                o_burst.has  = 1'b0;
            end
        end else if (w_full) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                n_win[i] = w_ins[i+1];
            end
            o_burst.data = w_flat;
            o_burst.has  = 1'b1;
            if (i_last) begin
                o_burst.cnt = BURST_CNT_W'(w_plen);
                n_fill      = '0;
            end else begin
                o_burst.cnt = BURST_CNT_W'(1);
                n_fill      = w_plen - LEN_W'(1);
            end
        end else if (i_last) begin
            o_burst.data = w_flat;
            o_burst.cnt  = BURST_CNT_W'(w_fill_inc);
            o_burst.has  = 1'b1;
            n_fill       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_clear) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

    `SSR_ASSERT_IMPLY(a_fill_below_plen, 1'b1, r_fill < w_plen)
    `SSR_ASSERT_NEXT(a_last_empties, i_accept && i_last, r_fill == '0)
    `SSR_ASSERT_IMPLY(a_match_clears, i_accept && w_full && w_eq, n_fill == '0)

endmodule

// ----- hw/rtl/stream_substring_replace.sv -----
// Latency: the first result word of an item is offered the cycle after the item is taken.
// Throughput: one byte per cycle while the output is ready; an item giving several results holds the input
// while the output burst register drains one word per accepted output word, until it is on its last word.
// Reset (synchronous, active low) empties the window and burst, and restores the registers.
// Depends on ssr_pkg, ssr_if, ssr_window and the assertion macro header.
`include "stream_substring_replace_assert.svh"

module stream_substring_replace #(
    parameter int PATTERN_MAX = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ssr_in_if.sink                            i_in,
    ssr_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [ssr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import ssr_pkg::*;

    logic [CFG_DATA_W-1:0]  r_pattern;
    logic [LEN_CFG_W-1:0]   r_plen;
    logic [CFG_DATA_W-1:0]  r_repl;
    logic [LEN_CFG_W-1:0]   r_rlen;
    logic [BURST_W-1:0]     r_data;
    logic [BURST_CNT_W-1:0] r_cnt;
    logic                   r_has;
    logic                   r_last;
    t_reg_idx               w_idx;
    t_burst                 w_burst;
    logic                   w_wr;
    logic                   in_fire;
    logic                   out_fire;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= LEN_CFG_W'(1);
            r_repl    <= '0;
            r_rlen    <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PATTERN_BYTES: r_pattern <= pwdata;
                REG_PATTERN_LEN:   r_plen    <= pwdata[LEN_CFG_W-1:0];
                REG_REPL_BYTES:    r_repl    <= pwdata;
                REG_REPL_LEN:      r_rlen    <= pwdata[LEN_CFG_W-1:0];
                default:           r_rlen    <= r_rlen;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PATTERN_BYTES: prdata = r_pattern;
            REG_PATTERN_LEN:   prdata = CFG_DATA_W'(r_plen);
            REG_REPL_BYTES:    prdata = r_repl;
            REG_REPL_LEN:      prdata = CFG_DATA_W'(r_rlen);
            default:           prdata = '0;
        endcase
    end

    ssr_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_fire),
        .i_clear       (w_wr && (w_idx == REG_PATTERN_LEN)),
        .i_byte        (i_in.in_byte),
        .i_last        (i_in.in_last),
        .i_pattern     (r_pattern),
        .i_pattern_len (r_plen),
        .i_repl        (r_repl),
        .i_repl_len    (r_rlen),
        .o_burst       (w_burst)
    );

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_data[BYTE_W-1:0];
    assign o_out.has_byte = r_has;
    assign o_out.out_last = r_last && (r_cnt == BURST_CNT_W'(1));

    assign out_fire   = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == '0) || ((r_cnt == BURST_CNT_W'(1)) && o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_fire && (w_burst.cnt != '0)) begin
            r_cnt <= w_burst.cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - BURST_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (w_burst.cnt != '0)) begin
            r_data <= w_burst.data;
            r_has  <= w_burst.has;
            r_last <= w_burst.last;
        end else if (out_fire) begin
            r_data <= r_data >> BYTE_W;
        end
    end

    `SSR_ASSERT_IMPLY(a_bare_is_last, o_out.valid && !o_out.has_byte,
                      o_out.out_last && (o_out.out_byte == '0))
    `SSR_ASSERT_IMPLY(a_cnt_bound, 1'b1, r_cnt <= BURST_CNT_W'(REPL_MAX))
    `SSR_ASSERT_NEXT(a_drain, out_fire && (r_cnt == BURST_CNT_W'(1)) && !in_fire,
                     r_cnt == '0)

endmodule
